>>> hw/rtl/arjb_pkg.sv
// ---------------------------------------------------------------------------
// arjb_pkg
// Shared constants, types and helpers of the adaptive resampling jitter buffer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package arjb_pkg;

  // store geometry and fixed-point layout
  localparam int DEPTH      = 2048;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int FRAC_BITS  = 12;
  localparam int POS_W      = ADDR_W + FRAC_BITS;
  localparam int FILL_W     = 26;
  localparam int SAMPLE_W   = 16;
  localparam int WEIGHT_W   = 8;
  localparam int MIX_W      = SAMPLE_W + WEIGHT_W + 2;

  // register widths
  localparam int STEP_W     = 12;
  localparam int PCT_W      = 7;
  localparam int TRIM_W     = PCT_W + 1;
  localparam int ADV_W      = STEP_W + 2;
  localparam int PCT_PROD_W = ADDR_W + PCT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = STEP_W;

  // fill level limits
  localparam logic signed [FILL_W-1:0] FILL_HI    = {1'b0, {(FILL_W-1){1'b1}}};
  localparam logic signed [FILL_W-1:0] FILL_LO    = {1'b1, {(FILL_W-1){1'b0}}};
  localparam logic signed [FILL_W:0]   ONE_SAMPLE = (FILL_W+1)'(64'd1 << FRAC_BITS);
  localparam logic signed [FILL_W-1:0] FILL_CAP   = FILL_W'((64'd1 << POS_W) - 64'd1);
  localparam logic signed [FILL_W-1:0] WAKE_LEVEL = FILL_W'(64'd1 << (POS_W - 1));
  localparam int                       PCT_SCALE  = 100;

  // register reset values
  localparam logic [STEP_W-1:0] RATE_STEP_INIT   = STEP_W'(2229);
  localparam logic [PCT_W-1:0]  TARGET_FILL_INIT = PCT_W'(70);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RATE_STEP   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_FILL = CFG_IDX_W'(1);

  // item operation codes
  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_PULL  = 2'd1,
    FUNC_FLUSH = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  // sample store access request
  typedef struct packed {
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic signed [SAMPLE_W-1:0] wr_data;
    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr_a;
    logic [ADDR_W-1:0]          rd_addr_b;
  } mem_req_t;

  // item held between control and output stage
  typedef struct packed {
    logic                valid;
    logic                interp;
    logic                ran_dry;
    logic                overflowed;
    logic                wake;
    logic [PCT_W-1:0]    percent;
    logic [WEIGHT_W-1:0] weight;
  } stage_t;

  // clamp a one-bit-grown fill value to the signed fill range
  function automatic logic signed [FILL_W-1:0] sat_fill(input logic signed [FILL_W:0] v);
    logic signed [FILL_W-1:0] r;
    if (v[FILL_W] != v[FILL_W-1]) begin
      r = v[FILL_W] ? FILL_LO : FILL_HI;
    end else begin
      r = v[FILL_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/arjb_store.sv
// ---------------------------------------------------------------------------
// arjb_store
// Sample ring memory: one write port, two registered read ports, and a
// zeroing sweep over every entry after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arjb_store
  import arjb_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire mem_req_t                   req,
  output logic                            busy,
  output logic signed [SAMPLE_W-1:0]      rd_a,
  output logic signed [SAMPLE_W-1:0]      rd_b
);

  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0]          clr_addr;
  logic                       clr_busy;

  assign busy = clr_busy;

  // zeroing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // write port
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_addr] <= '0;
    end else if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // neighbor read ports
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_a <= mem[req.rd_addr_a];
      rd_b <= mem[req.rd_addr_b];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/arjb_ctrl.sv
// ---------------------------------------------------------------------------
// arjb_ctrl
// Stream pointers, fill level, rate trim and configuration; issues store
// accesses and hands each item to the output stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arjb_ctrl
  import arjb_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  func,
  input  wire logic signed [SAMPLE_W-1:0]  sample_in,
  input  wire logic                        last_of_packet,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]       cfg_data,
  input  wire logic                        store_busy,
  input  wire logic                        s1_ready,
  output mem_req_t                         mem_req,
  output stage_t                           s1
);

  func_t                     op;
  logic                      accept;
  logic                      s1_take;

  logic [ADDR_W-1:0]         write_pos;
  logic [POS_W-1:0]          read_pos;
  logic signed [FILL_W-1:0]  fill;
  logic signed [TRIM_W-1:0]  rate_trim;
  logic [STEP_W-1:0]         rate_step;
  logic [PCT_W-1:0]          target_fill;
  logic                      v1;
  logic                      pkt_end;

  logic                      s1_interp;
  logic                      s1_ran_dry;
  logic                      s1_overflowed;
  logic                      s1_wake;
  logic [PCT_W-1:0]          s1_percent;
  logic [WEIGHT_W-1:0]       s1_weight;

  logic signed [ADV_W-1:0]   adv;
  logic signed [FILL_W-1:0]  fill_push;
  logic signed [FILL_W-1:0]  fill_pull;
  logic signed [FILL_W-1:0]  fill_after_pull;
  logic                      nonempty;
  logic [POS_W-1:0]          pos_pull;

  logic                      ovf;
  logic signed [FILL_W-1:0]  excess;
  logic [POS_W-1:0]          pos_drop;
  logic signed [FILL_W-1:0]  clamped;
  logic [ADDR_W-1:0]         whole;
  logic [PCT_PROD_W-1:0]     pct_prod;
  logic [PCT_W-1:0]          percent_c;
  logic                      wake_c;
  logic signed [TRIM_W-1:0]  trim_post;

  assign op        = func_t'(func);
  assign cfg_ready = 1'b1;
  assign in_ready  = !store_busy && !pkt_end && (!v1 || s1_ready);
  assign accept    = in_valid && in_ready;
  assign s1_take   = v1 && !pkt_end && s1_ready;

  // pull arithmetic
  assign adv       = $signed({2'b00, rate_step}) +
                     $signed({{(ADV_W-TRIM_W){rate_trim[TRIM_W-1]}}, rate_trim});
  assign nonempty  = !fill[FILL_W-1] && (fill != '0);
  assign fill_push = sat_fill({fill[FILL_W-1], fill} + ONE_SAMPLE);
  assign fill_pull = sat_fill({fill[FILL_W-1], fill} -
                              {{(FILL_W+1-ADV_W){adv[ADV_W-1]}}, adv});
  assign fill_after_pull = nonempty ? fill_pull : fill;
  assign pos_pull  = read_pos + {{(POS_W-ADV_W){adv[ADV_W-1]}}, adv};

  // packet end: overflow clamp, fill percentage and trim
  assign ovf       = fill > FILL_CAP;
  assign excess    = fill - FILL_CAP;
  assign pos_drop  = read_pos + excess[POS_W-1:0];
  assign clamped   = ovf ? FILL_CAP : fill;
  assign whole     = (!clamped[FILL_W-1] && (clamped != '0)) ?
                     clamped[POS_W-1:FRAC_BITS] : '0;
  assign pct_prod  = PCT_PROD_W'(whole) * PCT_PROD_W'(PCT_SCALE);
  assign percent_c = pct_prod[PCT_PROD_W-1:ADDR_W];
  assign wake_c    = clamped > WAKE_LEVEL;
  assign trim_post = $signed({1'b0, percent_c}) - $signed({1'b0, target_fill});

  // store accesses
  always_comb begin
    mem_req.wr_en     = accept && (op == FUNC_PUSH);
    mem_req.wr_addr   = write_pos;
    mem_req.wr_data   = sample_in;
    mem_req.rd_en     = accept && (op == FUNC_PULL);
    mem_req.rd_addr_a = read_pos[POS_W-1:FRAC_BITS];
    mem_req.rd_addr_b = read_pos[POS_W-1:FRAC_BITS] + ADDR_W'(1);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_step   <= RATE_STEP_INIT;
      target_fill <= TARGET_FILL_INIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RATE_STEP:   rate_step   <= cfg_data[STEP_W-1:0];
        REG_TARGET_FILL: target_fill <= cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos <= '0;
      read_pos  <= '0;
      fill      <= '0;
      rate_trim <= '0;
      pkt_end   <= 1'b0;
    end else if (pkt_end) begin
      pkt_end   <= 1'b0;
      rate_trim <= trim_post;
      if (ovf) begin
        read_pos <= pos_drop;
        fill     <= FILL_CAP;
      end
    end else if (accept) begin
      unique case (op)
        FUNC_PUSH: begin
          write_pos <= write_pos + ADDR_W'(1);
          fill      <= fill_push;
          pkt_end   <= last_of_packet;
        end
        FUNC_PULL: begin
          if (nonempty) begin
            read_pos <= pos_pull;
            fill     <= fill_pull;
          end
        end
        FUNC_FLUSH: begin
          write_pos <= '0;
          read_pos  <= '0;
          fill      <= '0;
          rate_trim <= TRIM_W'(0) - $signed({1'b0, target_fill});
        end
        default: ;
      endcase
    end
  end

  // item slot toward the output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (accept) begin
      v1 <= 1'b1;
    end else if (s1_take) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_end) begin
      s1_overflowed <= ovf;
      s1_wake       <= wake_c;
      s1_percent    <= percent_c;
    end else if (accept) begin
      s1_interp     <= (op == FUNC_PULL) && nonempty;
      s1_ran_dry    <= (op == FUNC_PULL) && fill_after_pull[FILL_W-1];
      s1_overflowed <= 1'b0;
      s1_wake       <= 1'b0;
      s1_percent    <= '0;
      s1_weight     <= read_pos[FRAC_BITS-1 -: WEIGHT_W];
    end
  end

  always_comb begin
    s1.valid      = v1 && !pkt_end;
    s1.interp     = s1_interp;
    s1.ran_dry    = s1_ran_dry;
    s1.overflowed = s1_overflowed;
    s1.wake       = s1_wake;
    s1.percent    = s1_percent;
    s1.weight     = s1_weight;
  end

endmodule

`default_nettype wire

>>> hw/rtl/arjb_interp.sv
// ---------------------------------------------------------------------------
// arjb_interp
// Linear blend of the two neighbor samples and the output result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arjb_interp
  import arjb_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire stage_t                      s1,
  input  wire logic signed [SAMPLE_W-1:0]  rd_a,
  input  wire logic signed [SAMPLE_W-1:0]  rd_b,
  output logic                             s1_ready,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [SAMPLE_W-1:0]       sample_out,
  output logic                             ran_dry,
  output logic                             overflowed,
  output logic                             wake_consumer,
  output logic [PCT_W-1:0]                 fill_percent
);

  logic                       take;
  logic [WEIGHT_W-1:0]        w_inv;
  logic signed [MIX_W-1:0]    prod_a;
  logic signed [MIX_W-1:0]    prod_b;
  logic signed [MIX_W-1:0]    mix;

  assign s1_ready = !out_valid || out_ready;
  assign take     = s1.valid && s1_ready;

  // (255 - w) * a + w * b, floored by 256
  assign w_inv  = ~s1.weight;
  assign prod_a = MIX_W'($signed({1'b0, w_inv})) * MIX_W'(rd_a);
  assign prod_b = MIX_W'($signed({1'b0, s1.weight})) * MIX_W'(rd_b);
  assign mix    = prod_a + prod_b;

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (take) begin
      sample_out    <= s1.interp ? mix[SAMPLE_W+WEIGHT_W-1:WEIGHT_W] : '0;
      ran_dry       <= s1.ran_dry;
      overflowed    <= s1.overflowed;
      wake_consumer <= s1.wake;
      fill_percent  <= s1.percent;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/adaptive_resampling_jitter_buffer_top.sv
// ---------------------------------------------------------------------------
// adaptive_resampling_jitter_buffer_top
// Audio jitter buffer with an adaptive-rate linear-interpolation resampler.
// ---------------------------------------------------------------------------
// Usage:
//   Input items (func, sample_in, last_of_packet) arrive on in_valid/in_ready;
//   func selects push, pull, stream flush or no operation. Every item gives
//   exactly one result item on out_valid/out_ready.
//   Registers rate_step (index 0) and target_fill_percent (index 1) are written
//   on cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always high.
//   An accepted item waits in the control item slot and then in the output
//   result register, where out_valid rises; a push that ends a packet first
//   passes a packet-end state that clamps overflow and sets the rate trim.
//   Throughput is one item per cycle unless the receiver stalls or a packet ends; the
//   sample store has two read ports, so both neighbors of a pull are read at once.
//   After reset the store zeroes all its entries, one entry per cycle, while
//   in_ready stays low; configuration writes are still taken then.
//   When the receiver stalls, the result waits in the output register, one
//   more item waits behind it, and in_ready then drops.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adaptive_resampling_jitter_buffer_top
  import arjb_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  func,
  input  wire logic signed [SAMPLE_W-1:0]  sample_in,
  input  wire logic                        last_of_packet,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [SAMPLE_W-1:0]       sample_out,
  output logic                             ran_dry,
  output logic                             overflowed,
  output logic                             wake_consumer,
  output logic [PCT_W-1:0]                 fill_percent,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]       cfg_data
);

  mem_req_t                   mem_req;
  stage_t                     s1;
  logic                       store_busy;
  logic                       s1_ready;
  logic signed [SAMPLE_W-1:0] rd_a;
  logic signed [SAMPLE_W-1:0] rd_b;

  // pointers, fill level and configuration
  arjb_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .sample_in      (sample_in),
    .last_of_packet (last_of_packet),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .store_busy     (store_busy),
    .s1_ready       (s1_ready),
    .mem_req        (mem_req),
    .s1             (s1)
  );

  // sample ring memory
  arjb_store u_store (
    .clk  (clk),
    .rst  (rst),
    .req  (mem_req),
    .busy (store_busy),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  // interpolation and result register
  arjb_interp u_interp (
    .clk           (clk),
    .rst           (rst),
    .s1            (s1),
    .rd_a          (rd_a),
    .rd_b          (rd_b),
    .s1_ready      (s1_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sample_out    (sample_out),
    .ran_dry       (ran_dry),
    .overflowed    (overflowed),
    .wake_consumer (wake_consumer),
    .fill_percent  (fill_percent)
  );

endmodule

`default_nettype wire

>>> dv/tb_adaptive_resampling_jitter_buffer_top.sv
// ---------------------------------------------------------------------------
// tb_adaptive_resampling_jitter_buffer_top
// Self-checking bench for the adaptive resampling jitter buffer. A scoreboard
// class mirrors the ring store, the fractional read pointer, the fill level
// and the rate trim. Each accepted item is predicted, and each result item is
// compared field by field in order. Stimulus covers directed edge cases,
// random packet traffic under several register settings, a drive to negative
// fill at packet end, and a ramp of packets past half full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_adaptive_resampling_jitter_buffer_top;
  import arjb_pkg::*;

  localparam int IDLE_PCT         = 37;
  localparam int TRAFFIC_LEN      = 32;
  localparam int RAMP_PACKETS     = 17;
  localparam int RAMP_PACKET_LEN  = 64;
  localparam int STEER_PACKET_LEN = 64;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

  // fill level bounds in sample fractions
  localparam longint ONE_LVL  = longint'(1) << FRAC_BITS;
  localparam longint LVL_MAX  = (longint'(1) << (FILL_W - 1)) - 1;
  localparam longint LVL_MIN  = -(longint'(1) << (FILL_W - 1));
  localparam longint LVL_CAP  = (longint'(DEPTH) << FRAC_BITS) - 1;
  localparam longint LVL_WAKE = longint'(DEPTH) << (FRAC_BITS - 1);

  // one result item
  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       dry;
    logic                       ovf;
    logic                       wake;
    logic [PCT_W-1:0]           pct;
  } output_t;

  // mirror of the buffer state plus the queue of outputs still due
  class jitter_buffer_scoreboard;
    logic signed [SAMPLE_W-1:0] pcm [DEPTH];
    logic [ADDR_W-1:0]          wr_ptr;
    logic [POS_W-1:0]           rd_phase;
    longint                     fill_q;
    int                         trim;
    logic [STEP_W-1:0]          step_reg;
    logic [PCT_W-1:0]           target_reg;
    output_t                    due_outputs[$];
    int errors, n_items, n_checked, n_overflow, n_dry, n_wake;

    function new();
      foreach (pcm[i]) pcm[i] = '0;
      wr_ptr     = '0;
      rd_phase   = '0;
      fill_q     = 0;
      trim       = 0;
      step_reg   = RATE_STEP_INIT;
      target_reg = TARGET_FILL_INIT;
      errors     = 0;
      n_items    = 0;
      n_checked  = 0;
      n_overflow = 0;
      n_dry      = 0;
      n_wake     = 0;
    endfunction

    function longint clip_level(input longint v);
      if (v > LVL_MAX) return LVL_MAX;
      if (v < LVL_MIN) return LVL_MIN;
      return v;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
      if (idx == REG_RATE_STEP) begin
        step_reg = data[STEP_W-1:0];
      end else if (idx == REG_TARGET_FILL) begin
        target_reg = data[PCT_W-1:0];
      end
    endfunction

    // advance the mirror by one accepted item and queue its output
    function void resample_item(input func_t op, input logic signed [SAMPLE_W-1:0] smp,
                                input logic last);
      output_t           r;
      logic [ADDR_W-1:0] idx;
      logic [ADDR_W-1:0] nxt;
      int                a, b, w, adv, mix, pct;
      r = '{sample: '0, dry: 1'b0, ovf: 1'b0, wake: 1'b0, pct: '0};
      n_items++;
      case (op)
        FUNC_PUSH: begin
          pcm[wr_ptr] = smp;
          wr_ptr      = wr_ptr + 1'b1;
          fill_q      = clip_level(fill_q + ONE_LVL);
          if (last) begin
            // overfull: drop the oldest audio by moving the read side
            if (fill_q > LVL_CAP) begin
              rd_phase = rd_phase + POS_W'(fill_q - LVL_CAP);
              fill_q   = LVL_CAP;
              r.ovf    = 1'b1;
              n_overflow++;
            end
            pct    = (fill_q <= 0) ? 0 : int'(((fill_q / ONE_LVL) * PCT_SCALE) / DEPTH);
            trim   = pct - int'(target_reg);
            r.pct  = PCT_W'(pct);
            r.wake = (fill_q > LVL_WAKE);
            if (r.wake) n_wake++;
          end
        end
        FUNC_PULL: begin
          if (fill_q > 0) begin
            // blend the two neighbors by the top bits of the fraction
            idx      = rd_phase[POS_W-1:FRAC_BITS];
            nxt      = idx + 1'b1;
            a        = pcm[idx];
            b        = pcm[nxt];
            w        = int'(rd_phase[FRAC_BITS-1 -: WEIGHT_W]);
            mix      = (255 - w) * a + w * b;
            r.sample = SAMPLE_W'(mix >>> 8);
            adv      = int'(step_reg) + trim;
            rd_phase = rd_phase + POS_W'(adv);
            fill_q   = clip_level(fill_q - adv);
          end
          r.dry = (fill_q < 0);
          if (r.dry) n_dry++;
        end
        FUNC_FLUSH: begin
          wr_ptr   = '0;
          rd_phase = '0;
          fill_q   = 0;
          trim     = -int'(target_reg);
        end
        default: begin
        end
      endcase
      due_outputs.push_back(r);
    endfunction

    task report(input string msg);
      errors++;
      $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // compare one result item with the oldest output due
    task check_output(input logic signed [SAMPLE_W-1:0] s, input logic d, input logic o,
                      input logic wk, input logic [PCT_W-1:0] p);
      output_t e;
      if (due_outputs.size() == 0) begin
        report("result item with no item outstanding");
        return;
      end
      e = due_outputs.pop_front();
      n_checked++;
      if (s !== e.sample) report($sformatf("sample_out got %0d want %0d", s, e.sample));
      if (d !== e.dry) report($sformatf("ran_dry got %b want %b", d, e.dry));
      if (o !== e.ovf) report($sformatf("overflowed got %b want %b", o, e.ovf));
      if (wk !== e.wake) report($sformatf("wake_consumer got %b want %b", wk, e.wake));
      if (p !== e.pct) report($sformatf("fill_percent got %0d want %0d", p, e.pct));
    endtask
  endclass

  logic                       clk            = 1'b0;
  logic                       rst            = 1'b1;
  logic                       in_valid       = 1'b0;
  logic                       in_ready;
  logic [1:0]                 func           = FUNC_NOP;
  logic signed [SAMPLE_W-1:0] sample_in      = '0;
  logic                       last_of_packet = 1'b0;
  logic                       out_valid;
  logic                       out_ready      = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       ran_dry;
  logic                       overflowed;
  logic                       wake_consumer;
  logic [PCT_W-1:0]           fill_percent;
  logic                       cfg_valid      = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index      = '0;
  logic [CFG_DATA_W-1:0]      cfg_data       = '0;

  logic calm       = 1'b0;
  int   n_settings = 1;

  jitter_buffer_scoreboard sb;

  adaptive_resampling_jitter_buffer_top u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .sample_in      (sample_in),
    .last_of_packet (last_of_packet),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .sample_out     (sample_out),
    .ran_dry        (ran_dry),
    .overflowed     (overflowed),
    .wake_consumer  (wake_consumer),
    .fill_percent   (fill_percent),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // receiver stalls
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_output(sample_out, ran_dry, overflowed, wake_consumer, fill_percent);
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] any_sample();
    return SAMPLE_W'($urandom);
  endfunction

  function automatic logic any_bit();
    return 1'($urandom);
  endfunction

  // offer one item, with random idle cycles ahead of it
  task automatic send_item(input func_t op, input logic signed [SAMPLE_W-1:0] smp,
                           input logic last);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    func           <= op;
    sample_in      <= smp;
    last_of_packet <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.resample_item(op, smp, last);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering items and wait for every due output plus the pipeline tail
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_outputs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic retune(input logic [STEP_W-1:0] step, input logic [PCT_W-1:0] target);
    settle();
    write_reg(REG_RATE_STEP, CFG_DATA_W'(step));
    write_reg(REG_TARGET_FILL, CFG_DATA_W'(target));
    n_settings++;
  endtask

  // random packets followed by pull bursts, with stray and ignored items mixed in
  task automatic run_traffic(input int budget);
    int done_cnt, roll, len, pulls;
    done_cnt = 0;
    while (done_cnt < budget) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        send_item(FUNC_NOP, any_sample(), any_bit());
      end else if (roll < 5) begin
        send_item(FUNC_FLUSH, any_sample(), any_bit());
        done_cnt++;
      end else if (roll < 10) begin
        send_item((roll < 7) ? FUNC_PUSH : FUNC_PULL, any_sample(), any_bit());
        done_cnt++;
      end else begin
        len = $urandom_range(1, 48);
        for (int k = 0; k < len; k++) send_item(FUNC_PUSH, any_sample(), k == len - 1);
        pulls = $urandom_range(len / 2, 3 * len);
        for (int k = 0; k < pulls; k++) send_item(FUNC_PULL, any_sample(), any_bit());
        done_cnt += len + pulls;
      end
    end
  endtask

  // run time limit
  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int k;
    int stride;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // writes to unused indexes must leave the registers alone
    write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));

    // full-scale samples, blending across neighbors, running dry
    send_item(FUNC_PUSH, 16'sh7FFF, 1'b0);
    send_item(FUNC_PUSH, 16'sh8000, 1'b0);
    send_item(FUNC_PUSH, '0, 1'b0);
    send_item(FUNC_PUSH, '1, 1'b1);
    send_item(FUNC_NOP, 16'sh5A5A, 1'b1);
    repeat (9) send_item(FUNC_PULL, any_sample(), any_bit());
    send_item(FUNC_NOP, '1, 1'b0);
    send_item(FUNC_FLUSH, any_sample(), any_bit());
    send_item(FUNC_PULL, any_sample(), any_bit());
    send_item(FUNC_PUSH, 16'sh8000, 1'b1);
    send_item(FUNC_PULL, any_sample(), any_bit());
    send_item(FUNC_PUSH, 16'sh7FFF, 1'b1);
    repeat (2) send_item(FUNC_PULL, any_sample(), any_bit());

    // random traffic across register settings, extremes included
    run_traffic(TRAFFIC_LEN);
    retune(STEP_W'(4095), PCT_W'(100));
    run_traffic(TRAFFIC_LEN);
    retune(STEP_W'(0), PCT_W'(0));
    calm = 1'b1;
    run_traffic(2 * TRAFFIC_LEN);
    calm = 1'b0;
    retune(STEP_W'(0), PCT_W'(100));
    run_traffic(TRAFFIC_LEN);
    retune(STEP_W'(1), PCT_W'($urandom_range(1, 99)));
    run_traffic(TRAFFIC_LEN);
    retune(STEP_W'($urandom), PCT_W'($urandom_range(0, 100)));
    run_traffic(TRAFFIC_LEN);

    // push the fill level below minus one sample so a packet end sees it non-positive
    retune(STEP_W'(4095), PCT_W'(0));
    send_item(FUNC_FLUSH, any_sample(), any_bit());
    for (k = 0; k < STEER_PACKET_LEN; k++) begin
      send_item(FUNC_PUSH, any_sample(), k == STEER_PACKET_LEN - 1);
    end
    stride = int'(sb.step_reg) + sb.trim;
    while (sb.fill_q > stride) send_item(FUNC_PULL, any_sample(), any_bit());
    // land the level on one fraction, then overshoot it by more than a sample
    retune(STEP_W'(sb.fill_q - 1 - sb.trim), PCT_W'(0));
    send_item(FUNC_PULL, any_sample(), any_bit());
    retune(STEP_W'(4095), PCT_W'(0));
    send_item(FUNC_PULL, any_sample(), any_bit());
    send_item(FUNC_PUSH, any_sample(), 1'b1);
    run_traffic(TRAFFIC_LEN / 2);

    // fill past half with a ramp of packets
    retune(RATE_STEP_INIT, TARGET_FILL_INIT);
    send_item(FUNC_FLUSH, any_sample(), any_bit());
    for (int p = 0; p < RAMP_PACKETS; p++) begin
      for (k = 0; k < RAMP_PACKET_LEN; k++) begin
        send_item(FUNC_PUSH, any_sample(), k == RAMP_PACKET_LEN - 1);
      end
      repeat ($urandom_range(0, 2)) send_item(FUNC_PULL, any_sample(), any_bit());
    end
    repeat (16) send_item(FUNC_PULL, any_sample(), any_bit());

    settle();
    $display("covered %0d items and %0d checked results over %0d register settings",
             sb.n_items, sb.n_checked, n_settings);
    $display("saw %0d overflow clamps, %0d dry pulls and %0d consumer wakeups",
             sb.n_overflow, sb.n_dry, sb.n_wake);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> adaptive_resampling_jitter_buffer_top.f
hw/rtl/arjb_pkg.sv
hw/rtl/arjb_store.sv
hw/rtl/arjb_ctrl.sv
hw/rtl/arjb_interp.sv
hw/rtl/adaptive_resampling_jitter_buffer_top.sv
dv/tb_adaptive_resampling_jitter_buffer_top.sv
